### rtl/truh_pkg.sv
// shared types and constants for the tick rollover uptime block
// no dependencies; used by the top level
package truh_pkg;

  localparam int unsigned TickW    = 32;
  localparam int unsigned RateW    = 20;
  localparam int unsigned UptimeW  = 32;
  localparam int unsigned TicksW   = 2 * TickW;
  localparam int unsigned Scale    = 100;
  localparam int unsigned ScaleW   = 7;
  localparam int unsigned FracDvdW = RateW + ScaleW;
  localparam int unsigned StepCntW = $clog2(TicksW);

  localparam logic [RateW-1:0] RateReset = RateW'(1000);
  localparam logic [RateW-1:0] RateMin   = RateW'(1);

  typedef enum logic [2:0] {
    StIdle,
    StDivWhole,
    StScale,
    StDivFrac,
    StOut
  } state_e;

endpackage

### rtl/tick_rollover_uptime_hundredths_unit.sv
// tick rollover uptime unit: extends 32-bit tick samples by a wrap count and
// scales the 64-bit count to hundredths of a second; depends on truh_pkg
//
//  channel | beat signals          | payload
//  --------+-----------------------+---------------------------
//  in      | in_valid_i/in_ready_o | now_ticks_i [31:0]
//  out     | out_valid_o/out_ready_i | uptime_hundredths_o [31:0]
//  cfg     | cfg_valid_i/cfg_ready_o | tick_rate_hz_i [19:0]
//
// from acceptance to the earliest result beat a beat passes through 64 steps
// of the shared restoring divide step for ticks / rate, a scale state, 27
// steps of the same unit for the fraction and the sum, and the output state;
// in_ready_o is high only when idle, so beats do not overlap;
// a stalled result holds the unit
// reset clears the rate to 1000 and the last sample and wrap count to zero
module tick_rollover_uptime_hundredths_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [truh_pkg::TickW-1:0]       now_ticks_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [truh_pkg::UptimeW-1:0]     uptime_hundredths_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [truh_pkg::RateW-1:0]       tick_rate_hz_i
);

  localparam int unsigned TickW    = truh_pkg::TickW;
  localparam int unsigned RateW    = truh_pkg::RateW;
  localparam int unsigned UptimeW  = truh_pkg::UptimeW;
  localparam int unsigned TicksW   = truh_pkg::TicksW;
  localparam int unsigned FracDvdW = truh_pkg::FracDvdW;
  localparam int unsigned StepCntW = truh_pkg::StepCntW;
  localparam logic [StepCntW-1:0] WholeLast = StepCntW'(TicksW - 1);
  localparam logic [StepCntW-1:0] FracLast  = StepCntW'(FracDvdW - 1);

  truh_pkg::state_e state_q, state_d;

  logic [RateW-1:0]    rate_q;
  logic [TickW-1:0]    prev_q;
  logic [TickW-1:0]    wrap_q;
  logic [TicksW-1:0]   dvd_q;
  logic [RateW-1:0]    prem_q;
  logic [UptimeW-1:0]  quo_q;
  logic [UptimeW-1:0]  whole_q;
  logic [UptimeW-1:0]  result_q;
  logic [StepCntW-1:0] cnt_q;

  logic               in_fire;
  logic               out_fire;
  logic [TickW-1:0]   wrap_next;
  logic [RateW-1:0]   divisor;
  logic [RateW:0]     shifted;
  logic [RateW-1:0]   diff;
  logic               ge;
  logic [RateW-1:0]   prem_step;
  logic [FracDvdW-1:0] rem100;
  logic [UptimeW-1:0] whole_next;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign cfg_ready_o = 1'b1;

  assign wrap_next = (now_ticks_i < prev_q) ? wrap_q + TickW'(1) : wrap_q;
  assign divisor   = (rate_q == '0) ? truh_pkg::RateMin : rate_q;

  // shared restoring divide step
  always_comb begin
    shifted   = {prem_q, dvd_q[TicksW-1]};
    diff      = shifted[RateW-1:0] - divisor;
    ge        = (shifted >= {1'b0, divisor});
    prem_step = ge ? diff : shifted[RateW-1:0];
  end

  // remainder times 100 as shifts and adds
  assign rem100 = (FracDvdW'(prem_q) << 6) + (FracDvdW'(prem_q) << 5)
                + (FracDvdW'(prem_q) << 2);
  assign whole_next = (quo_q << 6) + (quo_q << 5) + (quo_q << 2);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      truh_pkg::StIdle: begin
        if (in_fire) state_d = truh_pkg::StDivWhole;
      end
      truh_pkg::StDivWhole: begin
        if (cnt_q == WholeLast) state_d = truh_pkg::StScale;
      end
      truh_pkg::StScale: begin
        state_d = truh_pkg::StDivFrac;
      end
      truh_pkg::StDivFrac: begin
        if (cnt_q == FracLast) state_d = truh_pkg::StOut;
      end
      truh_pkg::StOut: begin
        if (out_fire) state_d = truh_pkg::StIdle;
      end
      default: state_d = truh_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      truh_pkg::StIdle: in_ready_o  = 1'b1;
      truh_pkg::StOut:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign uptime_hundredths_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= truh_pkg::StIdle;
      rate_q  <= truh_pkg::RateReset;
      prev_q  <= '0;
      wrap_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) rate_q <= tick_rate_hz_i;
      if (in_fire) begin
        prev_q <= now_ticks_i;
        wrap_q <= wrap_next;
      end
      if (state_q == truh_pkg::StDivWhole || state_q == truh_pkg::StDivFrac) begin
        cnt_q <= cnt_q + StepCntW'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      truh_pkg::StIdle: begin
        dvd_q  <= {wrap_next, now_ticks_i};
        prem_q <= '0;
        quo_q  <= '0;
      end
      truh_pkg::StDivWhole, truh_pkg::StDivFrac: begin
        dvd_q  <= {dvd_q[TicksW-2:0], 1'b0};
        prem_q <= prem_step;
        quo_q  <= {quo_q[UptimeW-2:0], ge};
        if (state_q == truh_pkg::StDivFrac && cnt_q == FracLast) begin
          result_q <= whole_q + {quo_q[UptimeW-2:0], ge};
        end
      end
      truh_pkg::StScale: begin
        whole_q <= whole_next;
        dvd_q   <= {rem100, (TicksW - FracDvdW)'(0)};
        prem_q  <= '0;
        quo_q   <= '0;
      end
      truh_pkg::StOut: ;
      default: ;
    endcase
  end

endmodule

### rtl/truh_checker.sv
// port-level checker for the tick rollover uptime unit, bound to the top level
// depends on the top level's port list only
module truh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] uptime_hundredths_o
);

  // result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(uptime_hundredths_o)))
    else $error("result beat dropped or changed while stalled");

  // one beat in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o && !out_valid_o))
    else $error("unit ready or done right after accepting a beat");

  // no new beat while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while result pending");

  // after a result is taken the unit is ready again
  a_ready_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> (in_ready_o && !out_valid_o))
    else $error("unit not idle after result beat");

endmodule

bind tick_rollover_uptime_hundredths_unit truh_checker u_truh_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .uptime_hundredths_o (uptime_hundredths_o)
);
